FILE: hw/rtl/udec_pkg.sv
// Shared types and byte-class constants for the UTF-8 byte stream decoder.
// No dependencies; imported by every module of the decoder.
package udec_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned CNT_W  = 2;

   // Lower and upper bounds of each byte class
   localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
   localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

   // Payload masks
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

   // Continuations expected after each lead byte
   localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
   localparam logic [CNT_W-1:0] CNT_LEAD2 = 2'd1;
   localparam logic [CNT_W-1:0] CNT_LEAD3 = 2'd2;
   localparam logic [CNT_W-1:0] CNT_LEAD4 = 2'd3;

   // One input beat held in the input register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] byte_in;
      logic              string_start;
   } in_beat_type;

   // Decoded result handed to the output register
   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] code_point;
      logic            error;
   } result_type;

endpackage

FILE: hw/rtl/udec_in_reg.sv
// Input register of the UTF-8 decoder: holds one request beat.
// Depends on udec_pkg.
module udec_in_reg
   import udec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic              req_string_start,
   input  logic              advance,
   output in_beat_type       beat
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              start_ff;

   // Take a new beat when empty or when the held one moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff  <= req_byte_in;
         start_ff <= req_string_start;
      end
   end

   assign beat.valid        = valid_ff;
   assign beat.byte_in      = byte_ff;
   assign beat.string_start = start_ff;

endmodule

FILE: hw/rtl/udec_decode.sv
// Decode stage of the UTF-8 decoder: sequence state and byte classification.
// Depends on udec_pkg.
module udec_decode
   import udec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  in_beat_type beat,
   input  logic        advance,
   output result_type  result
);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic [CP_W-1:0]  partial_ff, partial_in;
   logic             failed_ff, failed_in;

   logic [CNT_W-1:0] cur_pending;
   logic [CP_W-1:0]  cur_partial;
   logic             cur_failed;
   logic [CP_W-1:0]  shifted;
   logic [CNT_W-1:0] pending_dec;
   logic [BYTE_W-1:0] b;

   // A string start clears the state before the byte is decoded
   assign cur_pending = beat.string_start ? CNT_NONE : pending_ff;
   assign cur_partial = beat.string_start ? '0 : partial_ff;
   assign cur_failed  = beat.string_start ? 1'b0 : failed_ff;
   assign b           = beat.byte_in;
   assign shifted     = {cur_partial[CP_W-7:0], b[5:0]};
   assign pending_dec = cur_pending - CNT_W'(1);

   // Classify the byte and form the next state and the result
   always_comb begin
      pending_in        = cur_pending;
      partial_in        = cur_partial;
      failed_in         = cur_failed;
      result.valid      = 1'b0;
      result.code_point = '0;
      result.error      = 1'b0;
      if (!cur_failed) begin
         if (b inside {[8'h00:ASCII_MAX]}) begin
            result.valid = 1'b1;
            if (cur_pending == CNT_NONE) begin
               result.code_point = CP_W'(b);
            end else begin
               result.error = 1'b1;
               failed_in    = 1'b1;
               pending_in   = CNT_NONE;
               partial_in   = '0;
            end
         end else if (b inside {[CONT_MIN:CONT_MAX]}) begin
            if (cur_pending == CNT_NONE) begin
               result.valid = 1'b1;
               result.error = 1'b1;
               failed_in    = 1'b1;
               partial_in   = '0;
            end else begin
               partial_in = shifted;
               pending_in = pending_dec;
               if (pending_dec == CNT_NONE) begin
                  result.valid      = 1'b1;
                  result.code_point = shifted;
               end
            end
         end else if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
            pending_in = CNT_LEAD2;
            partial_in = CP_W'(b & LEAD2_MASK);
         end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
            pending_in = CNT_LEAD3;
            partial_in = CP_W'(b & LEAD3_MASK);
         end else if (b inside {[LEAD4_MIN:LEAD4_MAX]}) begin
            pending_in = CNT_LEAD4;
            partial_in = CP_W'(b & LEAD4_MASK);
         end else begin
            result.valid = 1'b1;
            result.error = 1'b1;
            failed_in    = 1'b1;
            pending_in   = CNT_NONE;
            partial_in   = '0;
         end
      end
   end

   // Update state only when the beat leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= CNT_NONE;
         partial_ff <= '0;
         failed_ff  <= 1'b0;
      end else if (advance) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

FILE: hw/rtl/udec_out_reg.sv
// Output register of the UTF-8 decoder: holds one result beat for the consumer.
// Depends on udec_pkg.
module udec_out_reg
   import udec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  result_type      result,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_error
);

   logic            valid_ff, valid_in;
   logic [CP_W-1:0] cp_ff;
   logic            err_ff;
   logic            open;

   // Register is free when empty or being drained this cycle
   assign open     = !valid_ff || rsp_ready;
   assign advance  = in_valid && open;
   assign valid_in = open ? (advance && result.valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload only for a beat that gives a result
   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         cp_ff  <= result.code_point;
         err_ff <= result.error;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_error      = err_ff;

endmodule

FILE: hw/rtl/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder: input register, decode, output register.
// Depends on udec_pkg, udec_in_reg, udec_decode and udec_out_reg.
//
//   channel | direction | ports                                   | handshake
//   req     | in        | req_byte_in[7:0], req_string_start      | req_valid / req_ready
//   rsp     | out       | rsp_code_point[20:0], rsp_error         | rsp_valid / rsp_ready
//
// One byte per cycle sustained while the result side drains; a stalled result can hold the flow.
// A taken byte passes the input register, then the decode logic, then the result register.
// A byte that completes no character (lead byte, inner continuation, ignored byte) gives no beat.
// Reset is synchronous and clears both valid flags and the sequence state.
// A stalled result holds rsp_*; req_ready drops only while both registers are full
// and rsp_ready is low.
module utf8_byte_stream_decoder
   import udec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic              req_string_start,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic              rsp_error
);

   in_beat_type beat;
   result_type  result;
   logic        advance;

   udec_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_string_start (req_string_start),
      .advance          (advance),
      .beat             (beat)
   );

   udec_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .advance (advance),
      .result  (result)
   );

   udec_out_reg u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (beat.valid),
      .result         (result),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_error      (rsp_error)
   );

endmodule

FILE: hw/rtl/udec_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on udec_pkg and utf8_byte_stream_decoder.
module udec_checker
   import udec_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CP_W-1:0]   rsp_code_point,
   input logic              rsp_error
);

   // Reset leaves no result showing
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Error beats carry a zero code point
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_code_point == '0))
      else $error("error beat with nonzero code point");

   // A draining consumer never blocks the producer
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while result side drains");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_code_point)
                                     && $stable(rsp_error)))
      else $error("stalled result changed");

   // Offered request beat stays up until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> req_valid)
      else $error("request beat withdrawn before it was taken");

endmodule

bind utf8_byte_stream_decoder udec_checker u_udec_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_code_point (rsp_code_point),
   .rsp_error      (rsp_error)
);
